// ===== hw/rtl/tve_pkg.sv =====
// ----------------------------------------------------------------------------
// tve_pkg
// shared constants and types for the touch velocity estimator
// ----------------------------------------------------------------------------
package tve_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_HISTORY_FRAMES = 4;
    localparam int DEF_VALUE_BITS     = 16;

    // number of touches carried by the frame word
    localparam int TOUCHES      = 5;
    localparam int COUNT_W      = 3;
    localparam int IDLE_W       = 4;

    // configuration port
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_CENTROID_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RING_WRAP     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_IDLE      = 2'd2;

    // register reset values
    localparam logic                RST_CENTROID_MODE = 1'b1;
    localparam logic                RST_RING_WRAP     = 1'b0;
    localparam logic [IDLE_W-1:0]   RST_MAX_IDLE      = 4'd3;

    // per-touch control from the frame sequencer to a lane
    typedef struct packed {
        logic centroid;   // compare sizes as well as locations
        logic wrap;       // circular wrap correction
        logic store;      // frame is stored on this edge
        logic active;     // touch lies below the touch count (every touch in raw mode)
    } t_lane_ctrl;

endpackage

// ===== hw/rtl/tve_lane.sv =====
// ----------------------------------------------------------------------------
// tve_lane
// history shift line and velocity for one touch
// ----------------------------------------------------------------------------
module tve_lane
    import tve_pkg::*;
#(
    parameter int HISTORY_FRAMES = DEF_HISTORY_FRAMES,
    parameter int VALUE_BITS     = DEF_VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [VALUE_BITS-1:0]        i_location,
    input  logic [VALUE_BITS-1:0]        i_size,
    input  t_lane_ctrl                   i_ctrl,
    output logic                         o_differs,
    output logic signed [VALUE_BITS:0]   o_velocity
);

    // wrap thresholds, floor of 0.9 and 0.1 of full scale
    localparam int WRAP_HIGH_I = (9 * (1 << VALUE_BITS)) / 10;
    localparam int WRAP_LOW_I  = (1 << VALUE_BITS) / 10;
    localparam logic [VALUE_BITS-1:0] WRAP_HIGH = WRAP_HIGH_I[VALUE_BITS-1:0];
    localparam logic [VALUE_BITS-1:0] WRAP_LOW  = WRAP_LOW_I[VALUE_BITS-1:0];

    // slot 0 is the newest stored frame, the last slot the oldest
    logic [VALUE_BITS-1:0] r_loc  [HISTORY_FRAMES];
    logic [VALUE_BITS-1:0] r_size [HISTORY_FRAMES];
    logic signed [VALUE_BITS:0] r_vel;

    logic                       w_fill;
    logic [VALUE_BITS-1:0]      w_old_loc;
    logic [VALUE_BITS+1:0]      w_new_ext;
    logic [VALUE_BITS+1:0]      w_old_ext;
    logic [VALUE_BITS+1:0]      w_diff;
    logic signed [VALUE_BITS:0] n_vel;

    // frame differs from the newest stored one
    assign o_differs = (r_loc[0] != i_location) ||
                       (i_ctrl.centroid && (r_size[0] != i_size));

    // touch starts or ends against the frame that becomes the oldest
    assign w_fill    = (i_size != '0) != (r_size[HISTORY_FRAMES-2] != '0);
    assign w_old_loc = w_fill ? i_location : r_loc[HISTORY_FRAMES-2];

    // newest minus oldest with optional wrap correction
    always_comb begin
        w_new_ext = {2'b00, i_location};
        w_old_ext = {2'b00, w_old_loc};
        if (i_ctrl.wrap) begin
            if (i_location > WRAP_HIGH && w_old_loc <= WRAP_LOW) begin
                w_old_ext = w_old_ext + {2'b01, {VALUE_BITS{1'b0}}};
            end else if (i_location <= WRAP_LOW && w_old_loc > WRAP_HIGH) begin
                w_new_ext = w_new_ext + {2'b01, {VALUE_BITS{1'b0}}};
            end
        end
        w_diff = w_new_ext - w_old_ext;
        n_vel  = i_ctrl.active ? signed'(w_diff[VALUE_BITS:0]) : '0;
    end

    // history update and held velocity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY_FRAMES; i++) begin
                r_loc[i]  <= '0;
                r_size[i] <= '0;
            end
            r_vel <= '0;
        end else if (i_ctrl.store) begin
            if (w_fill) begin
                for (int i = 0; i < HISTORY_FRAMES; i++) begin
                    r_loc[i]  <= i_location;
                    r_size[i] <= i_size;
                end
            end else begin
                for (int i = HISTORY_FRAMES - 1; i > 0; i--) begin
                    r_loc[i]  <= r_loc[i-1];
                    r_size[i] <= r_size[i-1];
                end
                r_loc[0]  <= i_location;
                r_size[0] <= i_size;
            end
            r_vel <= n_vel;
        end
    end

    assign o_velocity = r_vel;

endmodule

// ===== hw/rtl/touch_velocity_estimator.sv =====
// ----------------------------------------------------------------------------
// touch_velocity_estimator
// per-touch velocity from a stream of touch sensor frames
// ----------------------------------------------------------------------------
// the result word passes the input register, then the result register, and
// the input word waits in the input register while a result word is stalled
// throughput: 1 word per cycle; input stalls only while a result word waits
// reset (synchronous, active low) clears history, velocities, idle count,
// handshake state, and loads the configuration register defaults
module touch_velocity_estimator
    import tve_pkg::*;
#(
    parameter int HISTORY_FRAMES = DEF_HISTORY_FRAMES,
    parameter int VALUE_BITS     = DEF_VALUE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [VALUE_BITS-1:0]       i_location_0,
    input  logic [VALUE_BITS-1:0]       i_location_1,
    input  logic [VALUE_BITS-1:0]       i_location_2,
    input  logic [VALUE_BITS-1:0]       i_location_3,
    input  logic [VALUE_BITS-1:0]       i_location_4,
    input  logic [VALUE_BITS-1:0]       i_size_0,
    input  logic [VALUE_BITS-1:0]       i_size_1,
    input  logic [VALUE_BITS-1:0]       i_size_2,
    input  logic [VALUE_BITS-1:0]       i_size_3,
    input  logic [VALUE_BITS-1:0]       i_size_4,
    input  logic [COUNT_W-1:0]          i_touch_count,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [VALUE_BITS:0]  o_velocity_0,
    output logic signed [VALUE_BITS:0]  o_velocity_1,
    output logic signed [VALUE_BITS:0]  o_velocity_2,
    output logic signed [VALUE_BITS:0]  o_velocity_3,
    output logic signed [VALUE_BITS:0]  o_velocity_4,
    output logic                        o_frame_taken
);

    // configuration registers
    logic              r_centroid;
    logic              r_wrap;
    logic [IDLE_W-1:0] r_max_idle;

    // input register
    logic                  r_in_valid;
    logic [VALUE_BITS-1:0] r_loc  [TOUCHES];
    logic [VALUE_BITS-1:0] r_size [TOUCHES];
    logic [COUNT_W-1:0]    r_count;

    // result stage state
    logic              r_out_valid;
    logic              r_taken;
    logic [IDLE_W-1:0] r_idle;

    logic                       w_in_fire;
    logic                       w_advance;
    logic                       w_changed;
    logic                       w_forced;
    logic                       w_store;
    logic [COUNT_W-1:0]         w_active;
    logic [TOUCHES-1:0]         w_differs;
    logic [VALUE_BITS-1:0]      w_size [TOUCHES];
    t_lane_ctrl                 w_ctrl [TOUCHES];
    logic signed [VALUE_BITS:0] w_vel  [TOUCHES];

    // handshake: result stage runs when the output slot is free or draining
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_fire  = i_in_valid && !o_in_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centroid <= RST_CENTROID_MODE;
            r_wrap     <= RST_RING_WRAP;
            r_max_idle <= RST_MAX_IDLE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CENTROID_MODE: r_centroid <= i_cfg_data[0];
                CFG_RING_WRAP:     r_wrap     <= i_cfg_data[0];
                CFG_MAX_IDLE:      r_max_idle <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_loc[0]  <= i_location_0;
            r_loc[1]  <= i_location_1;
            r_loc[2]  <= i_location_2;
            r_loc[3]  <= i_location_3;
            r_loc[4]  <= i_location_4;
            r_size[0] <= i_size_0;
            r_size[1] <= i_size_1;
            r_size[2] <= i_size_2;
            r_size[3] <= i_size_3;
            r_size[4] <= i_size_4;
            r_count   <= i_touch_count;
        end
    end

    // raw mode uses location as size and all touches
    assign w_active = r_centroid ? r_count : COUNT_W'(TOUCHES);

    // store decision from change and idle count
    assign w_changed = |w_differs;
    assign w_forced  = !w_changed && (r_idle == r_max_idle);
    assign w_store   = w_changed || w_forced;

    // touch lanes
    for (genvar g = 0; g < TOUCHES; g++) begin : g_lane
        assign w_size[g] = r_centroid ? r_size[g] : r_loc[g];

        always_comb begin
            w_ctrl[g].centroid = r_centroid;
            w_ctrl[g].wrap     = r_wrap;
            w_ctrl[g].store    = w_advance && w_store;
            w_ctrl[g].active   = COUNT_W'(g) < w_active;
        end

        tve_lane #(
            .HISTORY_FRAMES (HISTORY_FRAMES),
            .VALUE_BITS     (VALUE_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_location (r_loc[g]),
            .i_size     (w_size[g]),
            .i_ctrl     (w_ctrl[g]),
            .o_differs  (w_differs[g]),
            .o_velocity (w_vel[g])
        );
    end

    // idle count, frame flag and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idle      <= '0;
            r_taken     <= 1'b0;
        end else begin
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_taken     <= w_store;
                if (w_changed) begin
                    r_idle <= '0;
                end else if (w_forced) begin
                    r_idle <= IDLE_W'(1);
                end else begin
                    r_idle <= r_idle + IDLE_W'(1);
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // held velocities change only when the result stage advances
    assign o_out_valid   = r_out_valid;
    assign o_frame_taken = r_taken;
    assign o_velocity_0  = w_vel[0];
    assign o_velocity_1  = w_vel[1];
    assign o_velocity_2  = w_vel[2];
    assign o_velocity_3  = w_vel[3];
    assign o_velocity_4  = w_vel[4];

endmodule

// ===== test/tb_touch_velocity_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_velocity_estimator
// self-checking bench for the touch velocity estimator: a directed run over
// field extremes, idle-forced stores, touch onset and offset, touch counts
// and circular wrap, then random frame walks under several register settings
// and handshake idling patterns, each result word checked field by field
// ----------------------------------------------------------------------------
import tve_pkg::*;

// one sensor frame, as driven onto the input ports
typedef struct packed {
    logic [TOUCHES-1:0][DEF_VALUE_BITS-1:0] location;
    logic [TOUCHES-1:0][DEF_VALUE_BITS-1:0] size;
    logic [COUNT_W-1:0]                     count;
} t_sensor_frame;

// one result word, as seen on the output ports
typedef struct packed {
    logic [TOUCHES-1:0][DEF_VALUE_BITS:0] velocity;
    logic                                 taken;
} t_velocity_word;

class velocity_scoreboard;
    // register copies
    bit                 centroid;
    bit                 wrap;
    logic [IDLE_W-1:0]  idle_limit;
    // frame history and held velocities
    logic [DEF_VALUE_BITS-1:0] loc_hist [DEF_HISTORY_FRAMES][TOUCHES];
    logic [DEF_VALUE_BITS-1:0] size_hist [DEF_HISTORY_FRAMES][TOUCHES];
    int                        newest;
    logic [IDLE_W-1:0]         idle_run;
    int                        held [TOUCHES];
    int                        near_top;
    int                        near_bottom;
    t_velocity_word            expected_words [$];
    int errors;
    int frames_noted;
    int words_checked;
    int frames_stored;

    function new();
        near_top    = (9 << DEF_VALUE_BITS) / 10;
        near_bottom = (1 << DEF_VALUE_BITS) / 10;
        centroid    = RST_CENTROID_MODE;
        wrap        = RST_RING_WRAP;
        idle_limit  = RST_MAX_IDLE;
        newest      = 0;
        idle_run    = '0;
        errors      = 0;
        frames_noted  = 0;
        words_checked = 0;
        frames_stored = 0;
        for (int h = 0; h < DEF_HISTORY_FRAMES; h++) begin
            for (int n = 0; n < TOUCHES; n++) begin
                loc_hist[h][n]  = '0;
                size_hist[h][n] = '0;
            end
        end
        for (int n = 0; n < TOUCHES; n++) held[n] = 0;
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    // accepted frame: update history and queue the word it should produce
    function void note_frame(t_sensor_frame f);
        logic [DEF_VALUE_BITS-1:0] loc [TOUCHES];
        logic [DEF_VALUE_BITS-1:0] sz [TOUCHES];
        int             active;
        bit             fresh;
        int             prev;
        int             nl;
        int             ol;
        t_velocity_word w;

        frames_noted++;
        for (int n = 0; n < TOUCHES; n++) begin
            loc[n] = f.location[n];
            sz[n]  = centroid ? f.size[n] : f.location[n];
        end
        active = centroid ? int'(f.count) : TOUCHES;

        // compare against the newest stored frame
        fresh = 1'b0;
        for (int n = 0; n < TOUCHES; n++) begin
            if (loc_hist[newest][n] != loc[n]) fresh = 1'b1;
            if (centroid && size_hist[newest][n] != sz[n]) fresh = 1'b1;
        end

        // unchanged frames are stored anyway once the idle run hits the limit
        if (fresh) begin
            idle_run = '0;
        end else if (idle_run == idle_limit) begin
            idle_run = IDLE_W'(1);
            fresh = 1'b1;
        end else begin
            idle_run = idle_run + 1'b1;
        end

        if (fresh) begin
            frames_stored++;
            newest = (newest + 1) % DEF_HISTORY_FRAMES;
            prev   = (newest + 1) % DEF_HISTORY_FRAMES;
            for (int n = 0; n < TOUCHES; n++) begin
                size_hist[newest][n] = sz[n];
                loc_hist[newest][n]  = loc[n];
            end
            for (int n = 0; n < TOUCHES; n++) begin
                // touch start or end restarts its history
                if ((size_hist[newest][n] != 0) != (size_hist[prev][n] != 0)) begin
                    for (int h = 0; h < DEF_HISTORY_FRAMES; h++) begin
                        size_hist[h][n] = size_hist[newest][n];
                        loc_hist[h][n]  = loc_hist[newest][n];
                    end
                end
                if (n < active) begin
                    nl = int'(loc_hist[newest][n]);
                    ol = int'(loc_hist[prev][n]);
                    // circular sensor: crossing the ends counts as a short move
                    if (wrap) begin
                        if (nl > near_top && ol <= near_bottom)
                            ol += 1 << DEF_VALUE_BITS;
                        else if (nl <= near_bottom && ol > near_top)
                            nl += 1 << DEF_VALUE_BITS;
                    end
                    held[n] = nl - ol;
                end else begin
                    held[n] = 0;
                end
            end
        end

        for (int n = 0; n < TOUCHES; n++) w.velocity[n] = held[n][DEF_VALUE_BITS:0];
        w.taken = fresh;
        expected_words.push_back(w);
    endfunction

    // accepted result word: compare with the oldest expected word
    function void check_word(t_velocity_word got);
        t_velocity_word want;

        words_checked++;
        if (expected_words.size() == 0) begin
            errors++;
            if (errors <= 40)
                $display("%0t unexpected word: velocity_0 %0d, frame_taken %0b",
                         $time, $signed(got.velocity[0]), got.taken);
            return;
        end
        want = expected_words.pop_front();
        for (int n = 0; n < TOUCHES; n++) begin
            if (got.velocity[n] !== want.velocity[n]) begin
                errors++;
                if (errors <= 40)
                    $display("%0t velocity_%0d: expected %0d, got %0d", $time, n,
                             $signed(want.velocity[n]), $signed(got.velocity[n]));
            end
        end
        if (got.taken !== want.taken) begin
            errors++;
            if (errors <= 40)
                $display("%0t frame_taken: expected %0b, got %0b",
                         $time, want.taken, got.taken);
        end
    endfunction
endclass

module tb_touch_velocity_estimator;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_INDEX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]      i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    t_sensor_frame              tx_frame;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [DEF_VALUE_BITS:0] o_velocity_0;
    logic signed [DEF_VALUE_BITS:0] o_velocity_1;
    logic signed [DEF_VALUE_BITS:0] o_velocity_2;
    logic signed [DEF_VALUE_BITS:0] o_velocity_3;
    logic signed [DEF_VALUE_BITS:0] o_velocity_4;
    logic                       o_frame_taken;
    t_velocity_word             rx_word;

    velocity_scoreboard scoreboard;
    t_sensor_frame      walk_frame;
    int                 hold_left;
    int                 send_idle_pct;
    int                 stall_pct;
    int                 settings_run;

    touch_velocity_estimator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_location_0   (tx_frame.location[0]),
        .i_location_1   (tx_frame.location[1]),
        .i_location_2   (tx_frame.location[2]),
        .i_location_3   (tx_frame.location[3]),
        .i_location_4   (tx_frame.location[4]),
        .i_size_0       (tx_frame.size[0]),
        .i_size_1       (tx_frame.size[1]),
        .i_size_2       (tx_frame.size[2]),
        .i_size_3       (tx_frame.size[3]),
        .i_size_4       (tx_frame.size[4]),
        .i_touch_count  (tx_frame.count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_velocity_0   (o_velocity_0),
        .o_velocity_1   (o_velocity_1),
        .o_velocity_2   (o_velocity_2),
        .o_velocity_3   (o_velocity_3),
        .o_velocity_4   (o_velocity_4),
        .o_frame_taken  (o_frame_taken)
    );

    assign rx_word = {o_velocity_4, o_velocity_3, o_velocity_2, o_velocity_1,
                      o_velocity_0, o_frame_taken};

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watch both handshakes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) scoreboard.note_frame(tx_frame);
            if (o_out_valid && !i_out_stall) scoreboard.check_word(rx_word);
        end
    end

    // give up on a hung run
    initial begin
        #2_000_000;
        $display("tb_touch_velocity_estimator: errors");
        $finish;
    end

    function automatic t_sensor_frame uniform_frame(logic [DEF_VALUE_BITS-1:0] loc,
                                                    logic [DEF_VALUE_BITS-1:0] sz,
                                                    logic [COUNT_W-1:0] cnt);
        t_sensor_frame f;
        for (int n = 0; n < TOUCHES; n++) begin
            f.location[n] = loc;
            f.size[n]     = sz;
        end
        f.count = cnt;
        return f;
    endfunction

    // next frame of the random walk
    function automatic t_sensor_frame next_frame(t_sensor_frame prev);
        t_sensor_frame f;
        int pick;
        int n;
        f = prev;
        pick = $urandom_range(99);
        if (pick < 55) begin
            // drift, sometimes jumping next to either end of the sensor
            for (n = 0; n < TOUCHES; n++) begin
                if ($urandom_range(1) == 1) begin
                    if ($urandom_range(3) == 0)
                        f.location[n] = $urandom_range(1) ? 16'($urandom_range(6553))
                                                          : 16'($urandom_range(65535, 58983));
                    else
                        f.location[n] = f.location[n] + 16'($urandom_range(4000)) - 16'd2000;
                end
            end
            if ($urandom_range(3) == 0)
                f.size[$urandom_range(TOUCHES - 1)] = 16'($urandom_range(65535, 1));
        end else if (pick < 75) begin
            // touch lifts or lands
            n = $urandom_range(TOUCHES - 1);
            f.size[n] = (f.size[n] != 0) ? 16'd0 : 16'($urandom_range(65535, 1));
            if ($urandom_range(1) == 1)
                f.location[n] = (f.size[n] == 0) ? 16'd0 : 16'($urandom_range(65535, 1));
            f.count = COUNT_W'($urandom_range(TOUCHES));
        end else if (pick < 85) begin
            f.count = COUNT_W'($urandom_range(7));
        end else if (pick < 93) begin
            // single bit change in one field
            n = $urandom_range(2 * TOUCHES);
            if (n < TOUCHES)
                f.location[n] ^= 16'd1 << $urandom_range(15);
            else if (n < 2 * TOUCHES)
                f.size[n - TOUCHES] ^= 16'd1 << $urandom_range(15);
            else
                f.count ^= 3'd1 << $urandom_range(2);
        end else begin
            // noise
            for (n = 0; n < TOUCHES; n++) begin
                f.location[n] = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(65535));
                f.size[n]     = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(65535));
            end
            f.count = COUNT_W'($urandom_range(7));
        end
        return f;
    endfunction

    // offer one word, then hold it until accepted
    task automatic send_frame(t_sensor_frame f);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        tx_frame   <= f;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // one edge first so the last accepted word is already noted
    task automatic wait_for_results();
        @(posedge i_clk);
        while (scoreboard.pending() != 0) @(posedge i_clk);
    endtask

    // write all three registers on an idle block
    task automatic apply_config(bit cm, bit rw, logic [IDLE_W-1:0] limit);
        settings_run++;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CENTROID_MODE;
        i_cfg_data  <= CFG_DATA_W'(cm);
        @(posedge i_clk);
        scoreboard.centroid = cm;
        i_cfg_index <= CFG_RING_WRAP;
        i_cfg_data  <= CFG_DATA_W'(rw);
        @(posedge i_clk);
        scoreboard.wrap = rw;
        i_cfg_index <= CFG_MAX_IDLE;
        i_cfg_data  <= CFG_DATA_W'(limit);
        @(posedge i_clk);
        scoreboard.idle_limit = limit;
        i_cfg_we <= 1'b0;
    endtask

    // one setting of the registers with a random frame walk
    task automatic run_phase(bit cm, bit rw, logic [IDLE_W-1:0] limit,
                             int idle_pct, int stall_chance, int words);
        wait_for_results();
        apply_config(cm, rw, limit);
        send_idle_pct = idle_pct;
        stall_pct     = stall_chance;
        for (int k = 0; k < words; k++) begin
            if (hold_left > 0) begin
                hold_left--;
            end else begin
                walk_frame = next_frame(walk_frame);
                // runs of repeats reach every idle limit
                if ($urandom_range(9) < 3) hold_left = $urandom_range(20, 1);
            end
            send_frame(walk_frame);
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        t_sensor_frame f;
        scoreboard    = new();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 0;
        settings_run  = 1;
        walk_frame    = uniform_frame(16'd30000, 16'd20000, 3'd5);
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_CENTROID_MODE;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        tx_frame    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: empty frames until the idle limit forces a store
        repeat (5) send_frame(uniform_frame(16'd0, 16'd0, 3'd0));
        // all touches land at full scale, then jump across the whole sensor
        send_frame(uniform_frame(16'hffff, 16'hffff, 3'd5));
        send_frame(uniform_frame(16'd0, 16'hffff, 3'd5));
        // touch count above the touch total
        send_frame(uniform_frame(16'hffff, 16'hffff, 3'd7));
        // only two touches counted
        f = uniform_frame(16'd20000, 16'd30000, 3'd2);
        f.location[3] = 16'd123;
        send_frame(f);
        // touch 0 lifts, then lands again at the far end
        f.size[0] = 16'd0;
        send_frame(f);
        f.size[0]     = 16'd1;
        f.location[0] = 16'hffff;
        send_frame(f);
        i_in_valid <= 1'b0;

        // raw mode with wrap correction and an idle limit of one
        wait_for_results();
        apply_config(1'b0, 1'b1, 4'd1);
        foreach (f.location[n]) f.location[n] = '0;
        send_frame(uniform_frame(16'd60000, 16'd5, 3'd0));
        send_frame(uniform_frame(16'd62000, 16'd5, 3'd0));
        send_frame(uniform_frame(16'd2000, 16'd9, 3'd0));
        repeat (3) send_frame(uniform_frame(16'd4000, 16'd1, 3'd0));
        send_frame(uniform_frame(16'd6553, 16'd0, 3'd0));
        send_frame(uniform_frame(16'd58983, 16'd0, 3'd0));
        send_frame(uniform_frame(16'd0, 16'd7, 3'd0));
        send_frame(uniform_frame(16'd58982, 16'd7, 3'd0));
        i_in_valid <= 1'b0;

        // random walks under several settings and idling patterns
        run_phase(1'b1, 1'b0, 4'd3,  0,  0,  140);
        run_phase(1'b1, 1'b1, 4'd15, 62, 0,  140);
        run_phase(1'b0, 1'b1, 4'd1,  0,  62, 140);
        run_phase(1'b1, 1'b1, 4'd0,  30, 30, 140);
        run_phase(1'b0, 1'b0, 4'd7,  62, 0,  140);
        run_phase(1'b1, 1'b1, 4'd2,  0,  0,  140);

        wait_for_results();
        repeat (8) @(posedge i_clk);
        $display("%0d frames over %0d register settings, %0d stored, %0d words checked",
                 scoreboard.frames_noted, settings_run, scoreboard.frames_stored,
                 scoreboard.words_checked);
        if (scoreboard.errors == 0 && scoreboard.pending() == 0)
            $display("tb_touch_velocity_estimator: clean");
        else
            $display("tb_touch_velocity_estimator: errors");
        $finish;
    end

endmodule
